/* src/mwbb_pkg.sv */
// ----------------------------------------------------------------------------
// mwbb_pkg
// Shared widths, register indexes and the configuration bundle of the
// mask window bounding box block.
// ----------------------------------------------------------------------------
package mwbb_pkg;

	localparam int DIM_W     = 13;
	localparam int END_W     = 14;
	localparam int THR_W     = 9;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 14;
	localparam int MAX_DIM_DEF = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_START    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_END      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COL_START    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COL_END      = 3'd6;

	localparam logic [DIM_W-1:0] NONE_MIN = '1;
	localparam logic [END_W-1:0] END_FULL = '1;

	// effective configuration seen by the datapath
	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] row_start;
		logic [END_W-1:0] row_end;
		logic [DIM_W-1:0] col_start;
		logic [END_W-1:0] col_end;
	} cfg_t;

endpackage

/* src/mwbb_if.sv */
// ----------------------------------------------------------------------------
// mwbb_pix_if / mwbb_box_if
// Valid/ready channels for the pixel stream and the bounding box results.
// ----------------------------------------------------------------------------
interface mwbb_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface mwbb_box_if;
	logic        valid;
	logic        ready;
	logic [12:0] top_row;
	logic [12:0] bottom_row_end;
	logic [12:0] left_col;
	logic [12:0] right_col_end;

	modport source (output valid, output top_row, output bottom_row_end,
		output left_col, output right_col_end, input ready);
	modport sink (input valid, input top_row, input bottom_row_end,
		input left_col, input right_col_end, output ready);
endinterface

/* src/mask_window_bounding_box_top.sv */
// ----------------------------------------------------------------------------
// mask_window_bounding_box_top
// Streaming bounding box of pixels at or above threshold inside a row/column window.
// ----------------------------------------------------------------------------
// channel  dir  payload                                           role
// pix      in   pixel[7:0]                                        raster pixels
// box      out  top_row, bottom_row_end, left_col, right_col_end  one per frame
// cfg      in   cfg_wen, cfg_index[2:0], cfg_data[13:0]           register write
//
// One pixel per clock unless a pending result holds the frame's last pixel; a
// request waits in the input register and updates the counters and min/max
// trackers as it leaves it. The frame's last pixel loads the result register.
// Reset clears the trackers and counters; no clearing pass is needed.
// A stalled result holds only the frame's last pixel; new pixels wait behind it.
module mask_window_bounding_box_top import mwbb_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	mwbb_pix_if.sink             pix,
	mwbb_box_if.source           box
);

	cfg_t cfg;

	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;

	logic [DIM_W-1:0] col_count_q;
	logic [DIM_W-1:0] row_count_q;
	logic [DIM_W-1:0] min_row_q;
	logic [DIM_W-1:0] max_row_q;
	logic [DIM_W-1:0] min_col_q;
	logic [DIM_W-1:0] max_col_q;
	logic [1:0]       hit_flags_q;

	logic [DIM_W-1:0] min_row_d;
	logic [DIM_W-1:0] max_row_d;
	logic [DIM_W-1:0] min_col_d;
	logic [DIM_W-1:0] max_col_d;
	logic [1:0]       hit_flags_d;

	logic             hit;
	logic             line_end;
	logic             last;
	logic             adv;
	logic [DIM_W:0]   col_next;
	logic [DIM_W:0]   row_next;
	logic [2*DIM_W-1:0] row_bounds;
	logic [2*DIM_W-1:0] col_bounds;

	logic             box_valid_q;

	function automatic logic [2*DIM_W-1:0] calc_bounds(
		input logic [DIM_W-1:0] minv,
		input logic [DIM_W-1:0] maxv,
		input logic             vld,
		input logic [DIM_W-1:0] start,
		input logic [DIM_W-1:0] size,
		input logic [END_W-1:0] e_end
	);
		logic [DIM_W-1:0] fb;
		logic [DIM_W-1:0] top;
		logic [DIM_W+1:0] top_p2;
		logic [DIM_W-1:0] res;
		fb     = (start > size) ? start : size;
		top    = (minv < fb) ? minv : fb;
		top_p2 = {2'b00, top} + (DIM_W+2)'(2);
		if (vld && maxv > top)
			res = maxv + DIM_W'(1);
		else if (!e_end[END_W-1] && {2'b00, e_end[DIM_W-1:0]} >= top_p2)
			res = top + DIM_W'(1);
		else
			res = e_end[DIM_W-1:0];
		return {top, res};
	endfunction

	mwbb_cfg_regs #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign col_next = {1'b0, col_count_q} + (DIM_W+1)'(1);
	assign row_next = {1'b0, row_count_q} + (DIM_W+1)'(1);
	assign line_end = col_next >= {1'b0, cfg.width};
	assign last     = line_end && (row_next >= {1'b0, cfg.height});
	assign hit      = {1'b0, pixel_s1} >= cfg.threshold;

	assign adv       = valid_s1 && (!last || !box_valid_q || box.ready);
	assign pix.ready = !valid_s1 || adv;

	always_comb begin
		min_row_d   = min_row_q;
		max_row_d   = max_row_q;
		min_col_d   = min_col_q;
		max_col_d   = max_col_q;
		hit_flags_d = hit_flags_q;
		if (hit) begin
			if (row_count_q >= cfg.row_start && row_count_q < min_row_q)
				min_row_d = row_count_q;
			if (!cfg.row_end[END_W-1] && row_count_q < cfg.row_end[DIM_W-1:0] &&
				(!hit_flags_q[0] || row_count_q > max_row_q)) begin
				max_row_d      = row_count_q;
				hit_flags_d[0] = 1'b1;
			end
			if (col_count_q >= cfg.col_start && col_count_q < min_col_q)
				min_col_d = col_count_q;
			if (!cfg.col_end[END_W-1] && col_count_q < cfg.col_end[DIM_W-1:0] &&
				(!hit_flags_q[1] || col_count_q > max_col_q)) begin
				max_col_d      = col_count_q;
				hit_flags_d[1] = 1'b1;
			end
		end
	end

	assign row_bounds = calc_bounds(min_row_d, max_row_d, hit_flags_d[0],
		cfg.row_start, cfg.height, cfg.row_end);
	assign col_bounds = calc_bounds(min_col_d, max_col_d, hit_flags_d[1],
		cfg.col_start, cfg.width, cfg.col_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.valid && pix.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready)
			pixel_s1 <= pix.pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
			min_row_q   <= NONE_MIN;
			max_row_q   <= '0;
			min_col_q   <= NONE_MIN;
			max_col_q   <= '0;
			hit_flags_q <= '0;
		end else if (adv) begin
			if (last) begin
				col_count_q <= '0;
				row_count_q <= '0;
				min_row_q   <= NONE_MIN;
				max_row_q   <= '0;
				min_col_q   <= NONE_MIN;
				max_col_q   <= '0;
				hit_flags_q <= '0;
			end else begin
				if (line_end) begin
					col_count_q <= '0;
					row_count_q <= row_next[DIM_W-1:0];
				end else begin
					col_count_q <= col_next[DIM_W-1:0];
				end
				min_row_q   <= min_row_d;
				max_row_q   <= max_row_d;
				min_col_q   <= min_col_d;
				max_col_q   <= max_col_d;
				hit_flags_q <= hit_flags_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q <= 1'b0;
		end else if (adv && last) begin
			box_valid_q <= 1'b1;
		end else if (box.ready) begin
			box_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last) begin
			box.top_row        <= row_bounds[2*DIM_W-1:DIM_W];
			box.bottom_row_end <= row_bounds[DIM_W-1:0];
			box.left_col       <= col_bounds[2*DIM_W-1:DIM_W];
			box.right_col_end  <= col_bounds[DIM_W-1:0];
		end
	end

	assign box.valid = box_valid_q;

endmodule

/* src/mwbb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mwbb_cfg_regs
// Configuration registers with size clamping and end resolution.
// ----------------------------------------------------------------------------
module mwbb_cfg_regs import mwbb_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	localparam logic [DIM_W+1:0] MaxDim = (DIM_W+2)'(MAX_DIM);

	logic [THR_W-1:0] threshold_q;
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [DIM_W-1:0] row_start_q;
	logic [END_W-1:0] row_end_q;
	logic [DIM_W-1:0] col_start_q;
	logic [END_W-1:0] col_end_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if ({2'b00, v} > MaxDim)
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= '0;
			image_width_q  <= DIM_W'(4096);
			image_height_q <= DIM_W'(4096);
			row_start_q    <= '0;
			row_end_q      <= END_FULL;
			col_start_q    <= '0;
			col_end_q      <= END_FULL;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[DIM_W-1:0];
				REG_ROW_START:    row_start_q    <= cfg_data[DIM_W-1:0];
				REG_ROW_END:      row_end_q      <= cfg_data[END_W-1:0];
				REG_COL_START:    col_start_q    <= cfg_data[DIM_W-1:0];
				REG_COL_END:      col_end_q      <= cfg_data[END_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = eff_size(image_width_q);
	assign h_eff = eff_size(image_height_q);

	always_comb begin
		cfg.threshold = threshold_q;
		cfg.width     = w_eff;
		cfg.height    = h_eff;
		cfg.row_start = row_start_q;
		cfg.col_start = col_start_q;
		cfg.row_end   = (row_end_q == END_FULL) ? {1'b0, h_eff} : row_end_q;
		cfg.col_end   = (col_end_q == END_FULL) ? {1'b0, w_eff} : col_end_q;
	end

endmodule
